[hw/rtl/wamp_pkg.sv]
// ----------------------------------------------------------------------------
// wamp_pkg
// Shared types, codes and widths of the window alpha mask pixel core.
// ----------------------------------------------------------------------------
package wamp_pkg;

  // op codes of an input transfer
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // register indexes of the configuration port
  localparam logic [2:0] REG_REGION_ENABLED = 3'd0;
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd1;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_VIS_LEFT       = 3'd3;
  localparam logic [2:0] REG_VIS_TOP        = 3'd4;
  localparam logic [2:0] REG_VIS_RIGHT      = 3'd5;
  localparam logic [2:0] REG_VIS_BOTTOM     = 3'd6;
  localparam logic [2:0] REG_ROUND_RAD      = 3'd7;

  // default sizes
  localparam int DEF_MAX_RECTS = 16;
  localparam int DEF_MAX_DIM   = 4096;

  // fixed field widths
  localparam int COORD_W = 15;
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 14;
  localparam int RAD_CW  = 12;
  localparam int CFG_W   = 15;

  // square root unit: radicand, root and remainder widths
  localparam int RAD_W          = 42;
  localparam int ROOT_W         = RAD_W / 2;
  localparam int REM_W          = ROOT_W + 2;
  localparam int SQRT_PER_STAGE = 3;
  localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;

  // what travels beside the radicand through the square root pipeline
  typedef struct packed {
    logic              corner;
    logic [7:0]        alpha;
    logic [RAD_CW-1:0] radius;
  } side_t;

  // clamp a signed coordinate into 0..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [COORD_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic signed [DIM_W+1:0] vs;
    logic signed [DIM_W+1:0] ls;
    vs = (DIM_W+2)'(v);
    ls = $signed({2'b00, lim});
    if (vs < 0) begin
      return '0;
    end else if (vs > ls) begin
      return lim;
    end else begin
      return vs[DIM_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/wamp_isqrt.sv]
// ----------------------------------------------------------------------------
// wamp_isqrt
// Pipelined integer square root, a few root bits per stage, with side data.
// ----------------------------------------------------------------------------
module wamp_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [wamp_pkg::RAD_W-1:0]    in_rad,
  input  wamp_pkg::side_t               in_side,
  output logic                          out_vld,
  output logic [wamp_pkg::ROOT_W-1:0]   out_root,
  output wamp_pkg::side_t               out_side
);
  import wamp_pkg::*;

  logic              vld  [0:SQRT_STAGES];
  logic [RAD_W-1:0]  rad  [0:SQRT_STAGES];
  logic [REM_W-1:0]  rem  [0:SQRT_STAGES];
  logic [ROOT_W-1:0] root [0:SQRT_STAGES];
  side_t             side [0:SQRT_STAGES];

  assign vld[0]  = in_vld;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [RAD_W-1:0]  rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // restoring digit recurrence, two radicand bits per root bit
    always_comb begin
      logic [REM_W-1:0] trial;
      rad_next  = rad[s];
      rem_next  = rem[s];
      root_next = root[s];
      for (int k = 0; k < SQRT_PER_STAGE; k++) begin
        rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
        rad_next = {rad_next[RAD_W-3:0], 2'b00};
        trial    = {root_next, 2'b01};
        if (rem_next >= trial) begin
          rem_next  = rem_next - trial;
          root_next = {root_next[ROOT_W-2:0], 1'b1};
        end else begin
          root_next = {root_next[ROOT_W-2:0], 1'b0};
        end
      end
    end

    logic              vld_q;
    logic [RAD_W-1:0]  rad_q;
    logic [REM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    side_t             side_q;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q  <= rad_next;
        rem_q  <= rem_next;
        root_q <= root_next;
        side_q <= side[s];
      end
    end

    assign vld[s+1]  = vld_q;
    assign rad[s+1]  = rad_q;
    assign rem[s+1]  = rem_q;
    assign root[s+1] = root_q;
    assign side[s+1] = side_q;
  end

  assign out_vld  = vld[SQRT_STAGES];
  assign out_root = root[SQRT_STAGES];
  assign out_side = side[SQRT_STAGES];

endmodule

[hw/rtl/window_alpha_mask_pixel_core.sv]
// ----------------------------------------------------------------------------
// window_alpha_mask_pixel_core
// Per-pixel window alpha mask with a rectangle table and rounded corners.
// ----------------------------------------------------------------------------
//  channel  | signals                               | moves
//  ---------+---------------------------------------+---------------------------
//  input    | in_valid / in_stall, op, rect_*, px   | clear, add or pixel query
//  output   | out_valid / out_stall, alpha          | one alpha per pixel query
//  config   | cfg_we, cfg_index, cfg_data           | register write, no wait
//
//  one transfer is taken every cycle while in_stall is low; a pixel query passes
//  the seven stage square root pipeline plus five surrounding stages.
//  clear and add update the table at the input transfer and give no answer.
//  the whole pipeline holds while the output stalls; in_stall follows it.
//  rst is synchronous; it empties the table and loads the register defaults.
// ----------------------------------------------------------------------------
module window_alpha_mask_pixel_core #(
  parameter int MAX_RECTS = wamp_pkg::DEF_MAX_RECTS,
  parameter int MAX_DIM   = wamp_pkg::DEF_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [wamp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic signed [wamp_pkg::COORD_W-1:0] rect_left,
  input  logic signed [wamp_pkg::COORD_W-1:0] rect_top,
  input  logic signed [wamp_pkg::COORD_W-1:0] rect_right,
  input  logic signed [wamp_pkg::COORD_W-1:0] rect_bottom,
  input  logic [wamp_pkg::PIX_W-1:0]          pixel_x,
  input  logic [wamp_pkg::PIX_W-1:0]          pixel_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          alpha
);
  import wamp_pkg::*;

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);

  // pipeline advance
  logic en;
  logic in_acc;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  // configuration registers
  logic                      region_enabled;
  logic [DIM_W-1:0]          frame_width;
  logic [DIM_W-1:0]          frame_height;
  logic signed [COORD_W-1:0] vis_left;
  logic signed [COORD_W-1:0] vis_top;
  logic signed [COORD_W-1:0] vis_right;
  logic signed [COORD_W-1:0] vis_bottom;
  logic [RAD_CW-1:0]         round_rad;
  logic [DIM_W-1:0]          cfg_dim;

  assign cfg_dim = ({1'b0, cfg_data[12:0]} > DIM_LIM) ? DIM_LIM : {1'b0, cfg_data[12:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_enabled <= 1'b0;
      frame_width    <= (DIM_LIM < DIM_W'(4096)) ? DIM_LIM : DIM_W'(4096);
      frame_height   <= (DIM_LIM < DIM_W'(4096)) ? DIM_LIM : DIM_W'(4096);
      vis_left       <= '0;
      vis_top        <= '0;
      vis_right      <= COORD_W'(4096);
      vis_bottom     <= COORD_W'(4096);
      round_rad      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_ENABLED: region_enabled <= cfg_data[0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_dim;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_dim;
        REG_VIS_LEFT:       vis_left       <= $signed(cfg_data);
        REG_VIS_TOP:        vis_top        <= $signed(cfg_data);
        REG_VIS_RIGHT:      vis_right      <= $signed(cfg_data);
        REG_VIS_BOTTOM:     vis_bottom     <= $signed(cfg_data);
        REG_ROUND_RAD:      round_rad      <= cfg_data[RAD_CW-1:0];
        default: ;
      endcase
    end
  end

  // clamped visible bounds and effective radius, held in registers
  logic [DIM_W-1:0]  vl, vt, vr, vb;
  logic              vis_empty;
  logic [RAD_CW-1:0] rad_eff;

  always_ff @(posedge clk) begin
    logic [DIM_W-1:0] cl, ct, cr, cb, hw, hh, hm;
    cl = clamp_dim(vis_left, frame_width);
    ct = clamp_dim(vis_top, frame_height);
    cr = clamp_dim(vis_right, frame_width);
    cb = clamp_dim(vis_bottom, frame_height);
    hw = (cr - cl) >> 1;
    hh = (cb - ct) >> 1;
    hm = (hw < hh) ? hw : hh;
    vl <= cl;
    vt <= ct;
    vr <= cr;
    vb <= cb;
    vis_empty <= (cr <= cl) || (cb <= ct);
    rad_eff <= ({2'b00, round_rad} < hm) ? round_rad : hm[RAD_CW-1:0];
  end

  // rectangle table
  logic signed [COORD_W-1:0] tbl_l [MAX_RECTS];
  logic signed [COORD_W-1:0] tbl_t [MAX_RECTS];
  logic signed [COORD_W-1:0] tbl_r [MAX_RECTS];
  logic signed [COORD_W-1:0] tbl_b [MAX_RECTS];
  logic [CNT_W-1:0]          rect_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count <= '0;
    end else if (in_acc) begin
      if (op == OP_CLEAR) begin
        rect_count <= '0;
      end else if (op == OP_ADD && rect_count < CNT_MAX) begin
        rect_count <= rect_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_ADD && rect_count < CNT_MAX) begin
      tbl_l[rect_count[IDX_W-1:0]] <= rect_left;
      tbl_t[rect_count[IDX_W-1:0]] <= rect_top;
      tbl_r[rect_count[IDX_W-1:0]] <= rect_right;
      tbl_b[rect_count[IDX_W-1:0]] <= rect_bottom;
    end
  end

  // stage 0: compare the pixel against every stored rectangle
  logic [MAX_RECTS-1:0] hit_vec;
  logic signed [COORD_W:0] sx, sy;
  assign sx = $signed({{(COORD_W+1-PIX_W){1'b0}}, pixel_x});
  assign sy = $signed({{(COORD_W+1-PIX_W){1'b0}}, pixel_y});

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_hit
    assign hit_vec[i] = (CNT_W'(i) < rect_count) &&
                        sx >= (COORD_W+1)'(tbl_l[i]) && sx < (COORD_W+1)'(tbl_r[i]) &&
                        sy >= (COORD_W+1)'(tbl_t[i]) && sy < (COORD_W+1)'(tbl_b[i]);
  end

  logic             s1_vld;
  logic [PIX_W-1:0] s1_x, s1_y;
  logic             s1_on, s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_acc && op == OP_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x   <= pixel_x;
      s1_y   <= pixel_y;
      s1_on  <= !region_enabled || (|hit_vec);
      s1_off <= ({2'b00, pixel_x} >= frame_width) || ({2'b00, pixel_y} >= frame_height);
    end
  end

  // stage 1: visible window and corner offsets
  logic [DIM_W:0]    px1, py1, r1;
  logic              xl, xr, yt, yb, vis_out;
  logic [RAD_CW-1:0] dxd, dyd;
  side_t             s1_side;

  assign px1 = {3'b000, s1_x};
  assign py1 = {3'b000, s1_y};
  assign r1  = {3'b000, rad_eff};
  assign xl  = px1 < ({1'b0, vl} + r1);
  assign xr  = px1 >= ({1'b0, vr} - r1);
  assign yt  = py1 < ({1'b0, vt} + r1);
  assign yb  = py1 >= ({1'b0, vb} - r1);
  assign vis_out = s1_x < vl || s1_x >= vr || s1_y < vt || s1_y >= vb;

  always_comb begin
    logic [DIM_W:0] tx, ty;
    tx  = xl ? ({1'b0, vl} + r1 - px1) : (px1 + r1 + 1'b1 - {1'b0, vr});
    ty  = yt ? ({1'b0, vt} + r1 - py1) : (py1 + r1 + 1'b1 - {1'b0, vb});
    dxd = tx[RAD_CW-1:0];
    dyd = ty[RAD_CW-1:0];
    s1_side.radius = rad_eff;
    s1_side.corner = 1'b0;
    s1_side.alpha  = s1_on ? 8'hff : 8'h00;
    if (s1_off) begin
      s1_side.alpha = 8'h00;
    end else if (vis_empty) begin
      s1_side.corner = 1'b0;
    end else if (vis_out) begin
      s1_side.alpha = 8'h00;
    end else if (rad_eff != '0 && (xl || xr) && (yt || yb)) begin
      s1_side.corner = 1'b1;
    end
  end

  logic          s2_vld;
  side_t         s2_side;
  logic [12:0]   s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_ax   <= {dxd, 1'b0} - 13'd1;
      s2_ay   <= {dyd, 1'b0} - 13'd1;
    end
  end

  // stage 2: squares of the doubled offsets less one
  logic        s3_vld;
  side_t       s3_side;
  logic [25:0] s3_sqx, s3_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s2_side;
      s3_sqx  <= s2_ax * s2_ax;
      s3_sqy  <= s2_ay * s2_ay;
    end
  end

  // stage 3: sum, scaled by 2^14 for eight fraction bits of root
  logic             s4_vld;
  side_t            s4_side;
  logic [RAD_W-1:0] s4_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= s3_side;
      s4_rad  <= {1'b0, ({1'b0, s3_sqx} + {1'b0, s3_sqy}), 14'd0};
    end
  end

  // square root pipeline
  logic              q_vld;
  logic [ROOT_W-1:0] q_root;
  side_t             q_side;

  wamp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s4_vld),
    .in_rad   (s4_rad),
    .in_side  (s4_side),
    .out_vld  (q_vld),
    .out_root (q_root),
    .out_side (q_side)
  );

  // last stage: coverage factor and scaling into the output register
  logic [7:0] alpha_next;

  always_comb begin
    logic signed [ROOT_W+1:0] f8;
    logic [15:0]              prod;
    f8 = $signed({2'b00, q_side.radius, 8'h80}) - $signed({1'b0, q_root});
    prod = '0;
    alpha_next = q_side.alpha;
    if (q_side.corner) begin
      if (f8 < 0) begin
        alpha_next = 8'h00;
      end else if (f8 < 256) begin
        prod = q_side.alpha * f8[7:0];
        alpha_next = prod[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha <= alpha_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rect_count <= CNT_MAX) else $error("rect table count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_CLEAR |=> rect_count == '0)
    else $error("clear transfer left rectangles in the table");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_ADD && rect_count < CNT_MAX
    |=> rect_count == $past(rect_count) + 1'b1)
    else $error("add transfer did not grow the table");

  a_stall_follows: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  a_radius_bound: assert property (@(posedge clk) disable iff (rst)
    rad_eff <= $past(round_rad)) else $error("corner radius grew past the setting");

endmodule

[dv/window_alpha_mask_pixel_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_alpha_mask_pixel_core_tb
// Drives clear, add, nop and pixel query transfers through several register
// settings with random gaps and output stalls, predicts every alpha byte and
// checks each output transfer in order against the prediction.
// ----------------------------------------------------------------------------

// alpha prediction and in-order check of output transfers
class alpha_scoreboard;
  int signed   rl[16], rt[16], rr[16], rb[16];
  int          count;
  bit          region_en;
  int          fw, fh, vl_r, vt_r, vr_r, vb_r, radius;
  logic [7:0]  pending[$];
  int          errors;

  function void reset_state();
    count = 0; region_en = 0; fw = 4096; fh = 4096;
    vl_r = 0; vt_r = 0; vr_r = 4096; vb_r = 4096; radius = 0;
    pending.delete(); errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [14:0] v);
    case (idx)
      wamp_pkg::REG_REGION_ENABLED: region_en = v[0];
      wamp_pkg::REG_FRAME_WIDTH:    fw = (v[12:0] > 4096) ? 4096 : int'(v[12:0]);
      wamp_pkg::REG_FRAME_HEIGHT:   fh = (v[12:0] > 4096) ? 4096 : int'(v[12:0]);
      wamp_pkg::REG_VIS_LEFT:       vl_r = int'($signed(v));
      wamp_pkg::REG_VIS_TOP:        vt_r = int'($signed(v));
      wamp_pkg::REG_VIS_RIGHT:      vr_r = int'($signed(v));
      wamp_pkg::REG_VIS_BOTTOM:     vb_r = int'($signed(v));
      wamp_pkg::REG_ROUND_RAD:      radius = int'(v[11:0]);
      default: ;
    endcase
  endfunction

  static function int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  static function longint root(longint unsigned n);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function logic [7:0] mask_alpha(int px, int py);
    int a, vl, vt, vr, vb, r, lx, ly;
    longint dx, dy, f;
    if (px >= fw || py >= fh) return 0;
    a = region_en ? 0 : 255;
    if (region_en)
      for (int i = 0; i < count; i++)
        if (px >= rl[i] && px < rr[i] && py >= rt[i] && py < rb[i]) a = 255;
    vl = clip(vl_r, 0, fw); vt = clip(vt_r, 0, fh);
    vr = clip(vr_r, 0, fw); vb = clip(vb_r, 0, fh);
    if (vr <= vl || vb <= vt) return a;
    if (px < vl || px >= vr || py < vt || py >= vb) return 0;
    r = radius;
    if ((vr - vl) / 2 < r) r = (vr - vl) / 2;
    if ((vb - vt) / 2 < r) r = (vb - vt) / 2;
    if (r <= 0) return a;
    if (px < vl + r) lx = px - vl;
    else if (px >= vr - r) lx = vr - 1 - px;
    else return a;
    if (py < vt + r) ly = py - vt;
    else if (py >= vb - r) ly = vb - 1 - py;
    else return a;
    dx = 2 * lx - 2 * r + 1; dy = 2 * ly - 2 * r + 1;
    f = longint'(r) * 256 + 128 - root((dx * dx + dy * dy) << 14);
    if (f < 0) f = 0;
    if (f >= 256) return a;
    return 8'((a * f) >> 8);
  endfunction

  // note an accepted input transfer
  function void note_input(logic [1:0] op, int l, int t, int r, int b, int px, int py);
    case (op)
      wamp_pkg::OP_CLEAR: count = 0;
      wamp_pkg::OP_ADD:
        if (count < 16) begin
          rl[count] = l; rt[count] = t; rr[count] = r; rb[count] = b; count++;
        end
      wamp_pkg::OP_PIXEL: pending.push_back(mask_alpha(px, py));
      default: ;
    endcase
  endfunction

  // check one output transfer
  function void check_alpha(logic [7:0] got);
    logic [7:0] want;
    if (pending.size() == 0) begin
      $error("alpha: unexpected output transfer, value %0d", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $error("alpha: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module window_alpha_mask_pixel_core_tb;
  import wamp_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] op = '0;
  logic signed [COORD_W-1:0] rect_left = '0, rect_top = '0, rect_right = '0, rect_bottom = '0;
  logic [PIX_W-1:0] pixel_x = '0, pixel_y = '0;
  logic out_valid, out_stall = 0;
  logic [7:0] alpha;

  alpha_scoreboard sb = new();
  bit hold_long = 0;

  window_alpha_mask_pixel_core dut (.*);

  always #10 clk = ~clk;

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // register write while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [14:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // offer one input transfer and wait for acceptance
  task automatic send(logic [1:0] o, int l, int t, int r, int b, int px, int py);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; op <= o;
    rect_left <= 15'(l); rect_top <= 15'(t); rect_right <= 15'(r); rect_bottom <= 15'(b);
    pixel_x <= 12'(px); pixel_y <= 12'(py);
    do @(posedge clk); while (in_stall);
    sb.note_input(o, l, t, r, b, px & 4095, py & 4095);
  endtask

  task automatic send_pixel(int px, int py);
    send(OP_PIXEL, $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
         $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384, px, py);
  endtask

  task automatic send_rect(int l, int t, int r, int b);
    send(OP_ADD, l, t, r, b, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int rcoord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // one random phase: settings, then a mix of ops
  task automatic random_phase(int n, int dim, int mode);
    int w, h, k;
    w = (mode == 0) ? 1 : $urandom_range(1, dim);
    h = (mode == 0) ? 1 : $urandom_range(1, dim);
    write_reg(REG_REGION_ENABLED, 15'($urandom_range(0, 1)));
    write_reg(REG_FRAME_WIDTH, 15'(w));
    write_reg(REG_FRAME_HEIGHT, 15'(h));
    write_reg(REG_VIS_LEFT, 15'(rcoord(w / 3 + 2)));
    write_reg(REG_VIS_TOP, 15'(rcoord(h / 3 + 2)));
    write_reg(REG_VIS_RIGHT, 15'(w - rcoord(w / 3 + 2)));
    write_reg(REG_VIS_BOTTOM, 15'(h - rcoord(h / 3 + 2)));
    write_reg(REG_ROUND_RAD, 15'($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                  : $urandom_range(0, dim / 2 + 1)));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 4) send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      else if (k < 6) send(OP_NOP, rcoord(8192), 0, 0, 0, $urandom_range(0, 4095), 0);
      else if (k < 20) begin
        int l, t;
        l = rcoord(w); t = rcoord(h);
        send_rect(l, t, l + $urandom_range(0, w), t + $urandom_range(0, h));
      end else if (k < 92)
        send_pixel($urandom_range(0, w + 1), $urandom_range(0, h + 1));
      else send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
    drain();
  endtask

  // output side: random stalls and one long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1;
          repeat (g) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_alpha(alpha);

  initial begin
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: defaults, extremes, corners and full table
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send(OP_NOP, 0, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_REGION_ENABLED, 15'd1);
    send_pixel(5, 5);
    send_rect(-8192, -8192, 8191, 8191);
    send_rect(-16384, 16383, 0, 0);
    send_pixel(4095, 0);
    for (int i = 0; i < 16; i++) send_rect(i, i, i + 2, i + 2);
    send_pixel(17, 17);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_pixel(3, 3);
    drain();
    write_reg(REG_REGION_ENABLED, 15'd0);
    write_reg(REG_FRAME_WIDTH, 15'd8191);
    write_reg(REG_FRAME_HEIGHT, 15'd0);
    send_pixel(0, 0);
    drain();
    write_reg(REG_FRAME_WIDTH, 15'd64);
    write_reg(REG_FRAME_HEIGHT, 15'd48);
    write_reg(REG_VIS_LEFT, 15'h4000);
    write_reg(REG_VIS_TOP, 15'd2);
    write_reg(REG_VIS_RIGHT, 15'h3fff);
    write_reg(REG_VIS_BOTTOM, 15'd40);
    write_reg(REG_ROUND_RAD, 15'hfff);
    send_pixel(0, 2); send_pixel(63, 39); send_pixel(1, 20); send_pixel(0, 1);
    drain();
    write_reg(REG_VIS_RIGHT, 15'h4000);
    send_pixel(10, 10);
    drain();
    // long receiver hold-off while inputs keep coming
    hold_long = 1;
    for (int i = 0; i < 60; i++) send_pixel($urandom_range(0, 70), $urandom_range(0, 50));
    drain();
    for (int p = 0; p < 20; p++)
      random_phase(55, (p == 3) ? 4096 : ((p % 2) ? 40 : 12), p % 7);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
